// ===== sv/abkf_pkg.sv =====
`timescale 1ns / 1ps

package abkf_pkg;

    // Word format of the filter state.
    localparam int WORD_W = 32;
    localparam int FRAC   = 24;

    // Operand and product widths of the shared multiplier.
    localparam int OPA_W  = 33;
    localparam int OPB_W  = 36;
    localparam int PROD_W = OPA_W + OPB_W;

    // Time step limits, 1 ms and 10 ms in Q0.24.
    localparam logic [17:0] DT_MIN = 18'd16777;
    localparam logic [17:0] DT_MAX = 18'd167772;

    // Reported angle limit, 180 degrees in Q16.16.
    localparam logic signed [31:0] ANGLE_OUT_MAX = 32'sd11796480;

    // Reset values.
    localparam logic signed [31:0] COV_AA_INIT = 32'sd167772160;
    localparam logic signed [31:0] COV_BB_INIT = 32'sd1677722;
    localparam logic [24:0] ANGLE_NOISE_INIT = 25'd16777;
    localparam logic [24:0] BIAS_NOISE_INIT  = 25'd50332;
    localparam logic [22:0] BIAS_LIMIT_INIT  = 23'd655360;

    localparam logic signed [31:0] WORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;

    // Configuration register indexes.
    localparam logic [1:0] CFG_ANGLE_NOISE = 2'd0;
    localparam logic [1:0] CFG_BIAS_NOISE  = 2'd1;
    localparam logic [1:0] CFG_BIAS_LIMIT  = 2'd2;

    // Multiply steps of one filter update, in issue order.
    typedef enum logic [3:0] {
        OP_DT_BB   = 4'd0,
        OP_DT_RATE = 4'd1,
        OP_DT_AA   = 4'd2,
        OP_BPN_DT  = 4'd3,
        OP_K0_Y    = 4'd4,
        OP_K1_Y    = 4'd5,
        OP_K1_AA   = 4'd6,
        OP_K0_AA   = 4'd7,
        OP_K1_AB   = 4'd8,
        OP_K0_AB   = 4'd9
    } op_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic mul_en;
        logic wb_en;
        op_t  op;
        logic div_start;
        logic out_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_done;
        logic out_free;
    } stat_t;

    // Saturate a widened sum to the signed word range.
    function automatic logic signed [31:0] sat_word(input logic signed [33:0] x);
        logic signed [31:0] r;
        if (x > 34'(WORD_MAX)) begin
            r = WORD_MAX;
        end else if (x < 34'(WORD_MIN)) begin
            r = WORD_MIN;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

    // Drop FRAC fraction bits, round half away from zero, saturate.
    function automatic logic signed [31:0] rnd_mul(input logic signed [PROD_W-1:0] p);
        logic                neg;
        logic [PROD_W-1:0]   mag;
        logic [PROD_W:0]     sum;
        logic [PROD_W-FRAC:0] q;
        logic                big;
        logic signed [31:0]  r;
        neg = p[PROD_W-1];
        mag = neg ? PROD_W'(-p) : PROD_W'(p);
        sum = {1'b0, mag} + (PROD_W+1)'(1 << (FRAC - 1));
        q   = sum[PROD_W:FRAC];
        big = |q[PROD_W-FRAC:31];
        if (neg) begin
            r = big ? WORD_MIN : -$signed({1'b0, q[30:0]});
        end else begin
            r = big ? WORD_MAX : $signed({1'b0, q[30:0]});
        end
        return r;
    endfunction

endpackage

// ===== sv/abkf_div.sv =====
`timescale 1ns / 1ps

module abkf_div (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic signed [31:0]  cov_aa,
    input  logic signed [31:0]  cov_ba,
    input  logic [26:0]         rn,
    output logic signed [31:0]  k0,
    output logic signed [31:0]  k1,
    output logic                done
);
    import abkf_pkg::*;

    logic               busy_reg, busy_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic               done_reg, done_next;
    logic               spos_reg, spos_next;
    logic [31:0]        den_reg, den_next;
    logic [31:0]        rem_reg [2];
    logic [31:0]        rem_next [2];
    logic [30:0]        q_reg [2];
    logic [30:0]        q_next [2];
    logic [30:0]        nsh_reg [2];
    logic [30:0]        nsh_next [2];
    logic               neg_reg [2];
    logic               neg_next [2];
    logic               ovf_reg [2];
    logic               ovf_next [2];
    logic signed [31:0] k_reg [2];
    logic signed [31:0] k_next [2];
    logic signed [32:0] s;
    logic signed [31:0] num [2];
    logic [31:0]        un [2];
    logic [32:0]        trial [2];
    logic [31:0]        qr [2];
    logic [31:0]        mag [2];

    assign s      = 33'(cov_aa) + $signed({6'b0, rn});
    assign num[0] = cov_aa;
    assign num[1] = cov_ba;

    // Two restoring divider lanes sharing one denominator, one quotient bit a cycle.
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        spos_next = spos_reg;
        den_next  = den_reg;
        for (int i = 0; i < 2; i++)
        begin
            rem_next[i] = rem_reg[i];
            q_next[i]   = q_reg[i];
            nsh_next[i] = nsh_reg[i];
            neg_next[i] = neg_reg[i];
            ovf_next[i] = ovf_reg[i];
            k_next[i]   = k_reg[i];
            un[i]       = num[i][31] ? 32'(-33'(num[i])) : 32'(num[i]);
            trial[i]    = {rem_reg[i], nsh_reg[i][30]};
            qr[i]       = {1'b0, q_reg[i]} + ({rem_reg[i], 1'b0} >= {1'b0, den_reg} ? 32'd1 : 32'd0);
            mag[i]      = ovf_reg[i] ? 32'h8000_0000 : qr[i];
        end
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = 5'd0;
            spos_next = !s[32] && (s != 33'sd0);
            den_next  = s[31:0];
            for (int i = 0; i < 2; i++)
            begin
                neg_next[i] = num[i][31];
                ovf_next[i] = {7'b0, un[i]} >= {s[31:0], 7'b0};
                rem_next[i] = {7'b0, un[i][31:7]};
                nsh_next[i] = {un[i][6:0], 24'b0};
                q_next[i]   = 31'd0;
            end
        end else if (busy_reg) begin
            if (cnt_reg == 5'd31) begin
                // Round, apply sign, saturate; the gains are zero if the denominator is not positive.
                busy_next = 1'b0;
                done_next = 1'b1;
                for (int i = 0; i < 2; i++)
                begin
                    if (!spos_reg) begin
                        k_next[i] = 32'sd0;
                    end else if (neg_reg[i]) begin
                        k_next[i] = 32'(-$signed({1'b0, mag[i]}));
                    end else begin
                        k_next[i] = mag[i][31] ? WORD_MAX : $signed(mag[i]);
                    end
                end
            end else begin
                cnt_next = cnt_reg + 5'd1;
                for (int i = 0; i < 2; i++)
                begin
                    nsh_next[i] = {nsh_reg[i][29:0], 1'b0};
                    if (trial[i] >= {1'b0, den_reg}) begin
                        rem_next[i] = 32'(trial[i] - {1'b0, den_reg});
                        q_next[i]   = {q_reg[i][29:0], 1'b1};
                    end else begin
                        rem_next[i] = trial[i][31:0];
                        q_next[i]   = {q_reg[i][29:0], 1'b0};
                    end
                end
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            cnt_reg  <= 5'd0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        spos_reg <= spos_next;
        den_reg  <= den_next;
        for (int i = 0; i < 2; i++)
        begin
            rem_reg[i] <= rem_next[i];
            q_reg[i]   <= q_next[i];
            nsh_reg[i] <= nsh_next[i];
            neg_reg[i] <= neg_next[i];
            ovf_reg[i] <= ovf_next[i];
            k_reg[i]   <= k_next[i];
        end
    end

    assign k0   = k_reg[0];
    assign k1   = k_reg[1];
    assign done = done_reg;

endmodule

// ===== sv/abkf_dp.sv =====
`timescale 1ns / 1ps

module abkf_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  abkf_pkg::cmd_t       cmd,
    output abkf_pkg::stat_t      stat,
    input  logic                 cfg_write_en,
    input  logic [1:0]           cfg_index,
    input  logic [24:0]          cfg_data,
    input  logic signed [24:0]   measured_angle,
    input  logic signed [24:0]   gyro_rate,
    input  logic [17:0]          time_step,
    input  logic [26:0]          measurement_noise,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [24:0]   filtered_angle,
    output logic signed [23:0]   estimated_bias
);
    import abkf_pkg::*;

    // Configuration.
    logic [24:0] apn_reg, bpn_reg;
    logic [22:0] lim_reg;

    // Filter state.
    logic signed [31:0] angle_reg, angle_next;
    logic signed [31:0] bias_reg, bias_next;
    logic signed [31:0] aa_reg, aa_next;
    logic signed [31:0] ab_reg, ab_next;
    logic signed [31:0] ba_reg, ba_next;
    logic signed [31:0] bb_reg, bb_next;
    logic               seeded_reg, seeded_next;

    // Per-request operands and temporaries.
    logic signed [24:0] meas_reg, meas_next;
    logic signed [24:0] rate_reg, rate_next;
    logic [17:0]        dt_reg, dt_next;
    logic [26:0]        rn_reg, rn_next;
    logic signed [31:0] t_reg, t_next;
    logic signed [32:0] y_reg, y_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;

    // Result.
    logic               ovalid_reg, ovalid_next;
    logic signed [24:0] fa_reg, fa_next;
    logic signed [23:0] eb_reg, eb_next;

    logic signed [OPA_W-1:0]  opa;
    logic signed [OPB_W-1:0]  opb;
    logic signed [PROD_W-1:0] prod;
    logic signed [31:0]       rnd;
    logic signed [31:0]       bsum;
    logic signed [31:0]       lim;
    logic signed [31:0]       k0, k1;
    logic                     div_done;
    logic [17:0]              dt_in;

    abkf_div u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.div_start),
        .cov_aa (aa_reg),
        .cov_ba (ba_reg),
        .rn     (rn_reg),
        .k0     (k0),
        .k1     (k1),
        .done   (div_done)
    );

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            apn_reg <= ANGLE_NOISE_INIT;
            bpn_reg <= BIAS_NOISE_INIT;
            lim_reg <= BIAS_LIMIT_INIT;
        end else if (cfg_write_en) begin
            unique case (cfg_index)
                CFG_ANGLE_NOISE: apn_reg <= cfg_data;
                CFG_BIAS_NOISE:  bpn_reg <= cfg_data;
                CFG_BIAS_LIMIT:  lim_reg <= cfg_data[22:0];
                default: ;
            endcase
        end
    end

    // Multiplier operand selection.
    always_comb
    begin
        unique case (cmd.op)
            OP_DT_BB:   begin opa = $signed({15'b0, dt_reg}); opb = 36'(bb_reg); end
            OP_DT_RATE: begin
                opa = $signed({15'b0, dt_reg});
                opb = 36'(33'(rate_reg) - 33'(bias_reg));
            end
            OP_DT_AA:   begin
                opa = $signed({15'b0, dt_reg});
                opb = 36'(t_reg) - 36'(ab_reg) - 36'(ba_reg) + $signed({11'b0, apn_reg});
            end
            OP_BPN_DT:  begin opa = $signed({15'b0, dt_reg}); opb = $signed({11'b0, bpn_reg}); end
            OP_K0_Y:    begin opa = 33'(k0); opb = 36'(y_reg); end
            OP_K1_Y:    begin opa = 33'(k1); opb = 36'(y_reg); end
            OP_K1_AA:   begin opa = 33'(k1); opb = 36'(aa_reg); end
            OP_K0_AA:   begin opa = 33'(k0); opb = 36'(aa_reg); end
            OP_K1_AB:   begin opa = 33'(k1); opb = 36'(ab_reg); end
            OP_K0_AB:   begin opa = 33'(k0); opb = 36'(ab_reg); end
            default:    begin opa = '0; opb = '0; end
        endcase
    end

    assign prod  = opa * opb;
    assign rnd   = rnd_mul(prod_reg);
    assign bsum  = sat_word(34'(bias_reg) + 34'(rnd));
    assign lim   = $signed({9'b0, lim_reg});
    assign dt_in = (time_step < DT_MIN) ? DT_MIN : ((time_step > DT_MAX) ? DT_MAX : time_step);

    // Next-state logic of the datapath.
    always_comb
    begin
        angle_next  = angle_reg;
        bias_next   = bias_reg;
        aa_next     = aa_reg;
        ab_next     = ab_reg;
        ba_next     = ba_reg;
        bb_next     = bb_reg;
        seeded_next = seeded_reg;
        meas_next   = meas_reg;
        rate_next   = rate_reg;
        dt_next     = dt_reg;
        rn_next     = rn_reg;
        t_next      = t_reg;
        y_next      = y_reg;
        prod_next   = prod_reg;
        ovalid_next = ovalid_reg;
        fa_next     = fa_reg;
        eb_next     = eb_reg;

        // Capture the request and seed the angle on the first one.
        if (cmd.load) begin
            meas_next = measured_angle;
            rate_next = gyro_rate;
            dt_next   = dt_in;
            rn_next   = measurement_noise;
            if (!seeded_reg) begin
                angle_next  = 32'(measured_angle);
                seeded_next = 1'b1;
            end
        end

        if (cmd.mul_en) begin
            prod_next = prod;
        end

        // Write back the rounded product.
        if (cmd.wb_en) begin
            unique case (cmd.op)
                OP_DT_BB:   t_next = rnd;
                OP_DT_RATE: angle_next = sat_word(34'(angle_reg) + 34'(rnd));
                OP_DT_AA:   begin
                    aa_next = sat_word(34'(aa_reg) + 34'(rnd));
                    ab_next = sat_word(34'(ab_reg) - 34'(t_reg));
                    ba_next = sat_word(34'(ba_reg) - 34'(t_reg));
                end
                OP_BPN_DT:  bb_next = sat_word(34'(bb_reg) + 34'(rnd));
                OP_K0_Y:    angle_next = sat_word(34'(angle_reg) + 34'(rnd));
                OP_K1_Y:    begin
                    if (bsum > lim) begin
                        bias_next = lim;
                    end else if (bsum < -lim) begin
                        bias_next = -lim;
                    end else begin
                        bias_next = bsum;
                    end
                end
                OP_K1_AA:   ba_next = sat_word(34'(ba_reg) - 34'(rnd));
                OP_K0_AA:   aa_next = sat_word(34'(aa_reg) - 34'(rnd));
                OP_K1_AB:   bb_next = sat_word(34'(bb_reg) - 34'(rnd));
                OP_K0_AB:   ab_next = sat_word(34'(ab_reg) - 34'(rnd));
                default: ;
            endcase
        end

        // Innovation, taken once prediction is complete.
        if (cmd.div_start) begin
            y_next = 33'(meas_reg) - 33'(angle_reg);
        end

        // Result register.
        if (cmd.out_load) begin
            ovalid_next = 1'b1;
            if (angle_reg > ANGLE_OUT_MAX) begin
                fa_next = ANGLE_OUT_MAX[24:0];
            end else if (angle_reg < -ANGLE_OUT_MAX) begin
                fa_next = 25'(-ANGLE_OUT_MAX);
            end else begin
                fa_next = angle_reg[24:0];
            end
            eb_next = bias_reg[23:0];
        end else if (out_ready) begin
            ovalid_next = 1'b0;
        end
    end

    // Filter state and result handshake.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            angle_reg  <= 32'sd0;
            bias_reg   <= 32'sd0;
            aa_reg     <= COV_AA_INIT;
            ab_reg     <= 32'sd0;
            ba_reg     <= 32'sd0;
            bb_reg     <= COV_BB_INIT;
            seeded_reg <= 1'b0;
            ovalid_reg <= 1'b0;
        end else begin
            angle_reg  <= angle_next;
            bias_reg   <= bias_next;
            aa_reg     <= aa_next;
            ab_reg     <= ab_next;
            ba_reg     <= ba_next;
            bb_reg     <= bb_next;
            seeded_reg <= seeded_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        meas_reg <= meas_next;
        rate_reg <= rate_next;
        dt_reg   <= dt_next;
        rn_reg   <= rn_next;
        t_reg    <= t_next;
        y_reg    <= y_next;
        prod_reg <= prod_next;
        fa_reg   <= fa_next;
        eb_reg   <= eb_next;
    end

    assign stat.div_done = div_done;
    assign stat.out_free = !ovalid_reg || out_ready;
    assign out_valid      = ovalid_reg;
    assign filtered_angle = fa_reg;
    assign estimated_bias = eb_reg;

endmodule

// ===== sv/abkf_ctrl.sv =====
`timescale 1ns / 1ps

module abkf_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  abkf_pkg::stat_t  stat,
    output abkf_pkg::cmd_t   cmd
);
    import abkf_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_WB   = 5'b00100,
        S_DIV  = 5'b01000,
        S_OUT  = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    op_t    op_reg, op_next;

    // Sequence the multiply steps, the gain division and the result.
    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        cmd.load      = 1'b0;
        cmd.mul_en    = 1'b0;
        cmd.wb_en     = 1'b0;
        cmd.op        = op_reg;
        cmd.div_start = 1'b0;
        cmd.out_load  = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    op_next    = OP_DT_BB;
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                cmd.mul_en = 1'b1;
                state_next = S_WB;
            end
            S_WB: begin
                cmd.wb_en = 1'b1;
                if (op_reg == OP_BPN_DT) begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end else if (op_reg == OP_K0_AB) begin
                    state_next = S_OUT;
                end else begin
                    op_next    = op_t'(op_reg + 4'd1);
                    state_next = S_MUL;
                end
            end
            S_DIV: begin
                if (stat.div_done) begin
                    op_next    = OP_K0_Y;
                    state_next = S_MUL;
                end
            end
            S_OUT: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
            op_reg    <= OP_DT_BB;
        end else begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

endmodule

// ===== sv/angle_bias_kalman_filter.sv =====
`timescale 1ns / 1ps

// Two-state angle and gyro-bias Kalman filter. Each request carries the
// accelerometer angle, the gyro rate, the time step and the measurement
// variance; one result with the filtered angle and the bias estimate follows.
// A request is captured, then runs ten multiplications on one shared
// multiplier and the two gain divisions, which run side by side in a
// restoring divider at one quotient bit a cycle, and then the result is
// loaded. A result that is not taken holds the block in that last step.
// A new request is taken as soon as the previous result sits in the
// output register. Configuration should be written only while no request is
// in flight.
module angle_bias_kalman_filter (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write_en,
    input  logic [1:0]          cfg_index,
    input  logic [24:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic signed [24:0]  measured_angle,
    input  logic signed [24:0]  gyro_rate,
    input  logic [17:0]         time_step,
    input  logic [26:0]         measurement_noise,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [24:0]  filtered_angle,
    output logic signed [23:0]  estimated_bias
);
    import abkf_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // Controller.
    abkf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath.
    abkf_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .stat              (stat),
        .cfg_write_en      (cfg_write_en),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .measured_angle    (measured_angle),
        .gyro_rate         (gyro_rate),
        .time_step         (time_step),
        .measurement_noise (measurement_noise),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .filtered_angle    (filtered_angle),
        .estimated_bias    (estimated_bias)
    );

endmodule
